// ===== design/mete_pkg.sv =====
package mete_pkg;

	localparam int FRAC_BITS_DEFAULT  = 26;
	localparam int COUNT_BITS_DEFAULT = 16;

	localparam int COORD_BITS  = 32;
	localparam int PROD_BITS   = 2 * COORD_BITS;
	localparam int ITER_BITS   = 16;
	localparam int RADIUS_BITS = 31;
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ITER_LIMIT            = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_ESCAPE_RADIUS_SQUARED = CFG_INDEX_BITS'(1);

	localparam logic [ITER_BITS-1:0]   ITER_LIMIT_RESET = ITER_BITS'(200);
	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET     = RADIUS_BITS'(268435456);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [PROD_BITS-1:0]  wide_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SQ_RE  = 6'b000010,
		ST_SQ_IM  = 6'b000100,
		ST_CROSS  = 6'b001000,
		ST_UPDATE = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	function automatic coord_t sat_coord(input wide_t x);
		wide_t hi;
		wide_t lo;
		hi = PROD_BITS'({1'b0, {(COORD_BITS-1){1'b1}}});
		lo = -hi - PROD_BITS'(1);
		if (x > hi) begin
			return coord_t'(hi);
		end else if (x < lo) begin
			return coord_t'(lo);
		end
		return coord_t'(x);
	endfunction

endpackage

// ===== design/mandelbrot_escape_time_core.sv =====
// mandelbrot escape-time counter
// input channel: in_valid/in_ready carry one point c (c_real, c_imag), signed fixed
// point with FRAC_BITS fraction bits. output channel: out_valid/out_ready carry the
// iteration_count for that point. config channel: cfg_valid/cfg_ready with cfg_index
// and cfg_data writes the iteration limit (index 0) or escape_radius_squared (index 1);
// cfg_ready is always high; the user must make writes only while the core is idle,
// and the core itself does not enforce this. one 32x32 multiplier is shared by the
// three products of each update, which steps through ST_SQ_RE, ST_SQ_IM, ST_CROSS
// and ST_UPDATE. a point goes to ST_FINISH when its count reaches the limit in
// ST_SQ_RE or when it escapes in ST_UPDATE. in_ready is high only while no point is
// being iterated, so a new point is not taken before the last one's count is loaded.
// the result sits in an output register, so a new point is taken while it waits;
// if the receiver still stalls when the next point finishes, the core holds that
// count until the register is free. reset clears the handshakes and loads
// an iteration limit of 200 and escape_radius_squared = 4.0.
module mandelbrot_escape_time_core #(
	parameter int FRAC_BITS  = mete_pkg::FRAC_BITS_DEFAULT,
	parameter int COUNT_BITS = mete_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [mete_pkg::COORD_BITS-1:0] c_real,
	input  logic signed [mete_pkg::COORD_BITS-1:0] c_imag,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [COUNT_BITS-1:0]                iteration_count,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mete_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [mete_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	mete_pkg::state_t state_q;
	logic [mete_pkg::ITER_BITS-1:0]   max_iter_q;
	logic [mete_pkg::RADIUS_BITS-1:0] radius_q;
	mete_pkg::coord_t cr_q, ci_q, zr_q, zi_q;
	mete_pkg::wide_t  prod_q, rr_q, ii_q;
	logic esc_q;
	logic [mete_pkg::ITER_BITS-1:0] count_q;
	logic out_valid_q;
	logic [COUNT_BITS-1:0] out_count_q;

	mete_pkg::coord_t mul_a, mul_b;
	mete_pkg::wide_t  mul_p;
	mete_pkg::wide_t  sq_scaled, mag, new_re, new_im;
	logic out_free;

	assign in_ready        = (state_q == mete_pkg::ST_IDLE);
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign iteration_count = out_count_q;
	assign out_free        = !out_valid_q || out_ready;

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			mete_pkg::ST_SQ_RE: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			mete_pkg::ST_SQ_IM: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
		endcase
	end

	assign mul_p     = mul_a * mul_b;
	assign sq_scaled = prod_q >>> FRAC_BITS;
	assign mag       = rr_q + sq_scaled;
	assign new_re    = rr_q - ii_q + mete_pkg::PROD_BITS'(cr_q);
	assign new_im    = (prod_q >>> (FRAC_BITS - 1)) + mete_pkg::PROD_BITS'(ci_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= mete_pkg::ITER_LIMIT_RESET;
			radius_q   <= mete_pkg::RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mete_pkg::REG_ITER_LIMIT: begin
					max_iter_q <= cfg_data[mete_pkg::ITER_BITS-1:0];
				end
				mete_pkg::REG_ESCAPE_RADIUS_SQUARED: begin
					radius_q <= cfg_data[mete_pkg::RADIUS_BITS-1:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mete_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == mete_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				mete_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= mete_pkg::ST_SQ_RE;
					end
				end
				mete_pkg::ST_SQ_RE: begin
					if (count_q == max_iter_q) begin
						state_q <= mete_pkg::ST_FINISH;
					end else begin
						state_q <= mete_pkg::ST_SQ_IM;
					end
				end
				mete_pkg::ST_SQ_IM:  state_q <= mete_pkg::ST_CROSS;
				mete_pkg::ST_CROSS:  state_q <= mete_pkg::ST_UPDATE;
				mete_pkg::ST_UPDATE: begin
					if (esc_q) begin
						state_q <= mete_pkg::ST_FINISH;
					end else begin
						state_q <= mete_pkg::ST_SQ_RE;
					end
				end
				mete_pkg::ST_FINISH: begin
					if (out_free) begin
						state_q <= mete_pkg::ST_IDLE;
					end
				end
				default: state_q <= mete_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (state_q)
			mete_pkg::ST_IDLE: begin
				cr_q    <= c_real;
				ci_q    <= c_imag;
				zr_q    <= '0;
				zi_q    <= '0;
				count_q <= '0;
			end
			mete_pkg::ST_SQ_IM: begin
				rr_q <= sq_scaled;
			end
			mete_pkg::ST_CROSS: begin
				ii_q  <= sq_scaled;
				esc_q <= $unsigned(mag) > mete_pkg::PROD_BITS'(radius_q);
			end
			mete_pkg::ST_UPDATE: begin
				if (!esc_q) begin
					zr_q    <= mete_pkg::sat_coord(new_re);
					zi_q    <= mete_pkg::sat_coord(new_im);
					count_q <= count_q + mete_pkg::ITER_BITS'(1);
				end
			end
			mete_pkg::ST_FINISH: begin
				if (out_free) begin
					out_count_q <= COUNT_BITS'(count_q);
				end
			end
			default: ;
		endcase
	end

endmodule
